/* rtl/cfr_pkg.sv */
`timescale 1ns / 1ps

package cfr_pkg;

  localparam int unsigned WIN_DEPTH = 8;

  localparam logic [7:0] HEAD_BYTE = 8'h5E;
  localparam logic [7:0] TAIL_BYTE = 8'h4D;

  // command byte class and sub-field patterns
  localparam logic [1:0] CMD_CLASS_MOVE  = 2'b01;
  localparam logic [1:0] CMD_SUB_FWD     = 2'b00;
  localparam logic [1:0] CMD_SUB_BACK    = 2'b01;
  localparam logic [1:0] CMD_SUB_TURN    = 2'b10;
  localparam logic [5:0] CMD_SPIRAL_ON   = 6'h3F;
  localparam logic [5:0] CMD_SPIRAL_OFF  = 6'h30;

  localparam logic [2:0] ACT_NONE        = 3'd0;
  localparam logic [2:0] ACT_FORWARD     = 3'd1;
  localparam logic [2:0] ACT_BACK        = 3'd2;
  localparam logic [2:0] ACT_TURN        = 3'd3;
  localparam logic [2:0] ACT_SPIRAL_ON   = 3'd4;
  localparam logic [2:0] ACT_SPIRAL_OFF  = 3'd5;

  localparam int unsigned NUM_W    = 11;
  localparam int unsigned OUT_W    = 40;
  localparam int unsigned IN_W     = 8;

  typedef logic [7:0] byte_t;

  // frame seen by the detector, handed to the decoder
  typedef struct packed {
    logic  hit;
    byte_t cmd;
    byte_t b3;
    byte_t b4;
    byte_t b5;
  } frame_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [NUM_W-1:0] speed;
    logic [NUM_W-1:0] heading;
    byte_t            command_code;
  } result_t;

endpackage

/* rtl/cfr_window.sv */
`timescale 1ns / 1ps

module cfr_window (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  cfr_pkg::byte_t rx_byte,
  output cfr_pkg::frame_t frame
);
  import cfr_pkg::*;

  byte_t win_r   [WIN_DEPTH];
  byte_t win_nxt [WIN_DEPTH];
  byte_t shifted [WIN_DEPTH];
  byte_t csum;
  logic  hit;

  always_comb begin
    for (int k = 0; k < WIN_DEPTH - 1; k++) begin
      shifted[k] = win_r[k+1];
    end
    shifted[WIN_DEPTH-1] = rx_byte;
  end

  assign csum = shifted[2] + shifted[3] + shifted[4] + shifted[5];

  assign hit = (shifted[0] == HEAD_BYTE) && (shifted[1] == HEAD_BYTE) &&
               (shifted[7] == TAIL_BYTE) && (csum == shifted[6]);

  // a recognised frame flushes the window so its bytes are not reused
  always_comb begin
    for (int k = 0; k < WIN_DEPTH; k++) begin
      win_nxt[k] = hit ? 8'h00 : shifted[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_r[k] <= 8'h00;
      end
    end else if (step) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  assign frame.hit = hit;
  assign frame.cmd = shifted[2];
  assign frame.b3  = shifted[3];
  assign frame.b4  = shifted[4];
  assign frame.b5  = shifted[5];

  a_clear_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    step && hit |=> (win_r[0] == 8'h00) && (win_r[6] == 8'h00) && (win_r[7] == 8'h00))
    else $error("window not flushed after frame");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(win_r[7]) && $stable(win_r[0]))
    else $error("window moved without a byte");

endmodule

/* rtl/cfr_decode.sv */
`timescale 1ns / 1ps

module cfr_decode (
  input  cfr_pkg::frame_t  frame,
  output cfr_pkg::result_t res
);
  import cfr_pkg::*;

  logic [2:0] action;

  function automatic logic [NUM_W-1:0] bcd3(input logic [3:0] h, input logic [3:0] t,
                                            input logic [3:0] u);
    logic [NUM_W-1:0] hv;
    logic [NUM_W-1:0] tv;
    hv = NUM_W'(h) * NUM_W'(100);
    tv = NUM_W'(t) * NUM_W'(10);
    return hv + tv + NUM_W'(u);
  endfunction

  always_comb begin
    action = ACT_NONE;
    if (frame.cmd[7:6] == CMD_CLASS_MOVE) begin
      case (frame.cmd[5:4])
        CMD_SUB_FWD:  action = ACT_FORWARD;
        CMD_SUB_BACK: action = ACT_BACK;
        CMD_SUB_TURN: action = ACT_TURN;
        default: begin
          if (frame.cmd[5:0] == CMD_SPIRAL_ON) begin
            action = ACT_SPIRAL_ON;
          end else if (frame.cmd[5:0] == CMD_SPIRAL_OFF) begin
            action = ACT_SPIRAL_OFF;
          end else begin
            action = ACT_NONE;
          end
        end
      endcase
    end
  end

  assign res.action       = action;
  assign res.speed        = bcd3(frame.b3[7:4], frame.b3[3:0], frame.b4[7:4]);
  assign res.heading      = bcd3(frame.b4[3:0], frame.b5[7:4], frame.b5[3:0]);
  assign res.command_code = frame.cmd;

endmodule

/* rtl/command_frame_receiver_core.sv */
`timescale 1ns / 1ps

// Command frame receiver: takes one received serial byte per input item and
// watches the last eight for the frame 5E 5E cmd p0 p1 p2 sum 4D, where sum is
// the low byte of cmd+p0+p1+p2. Each recognised frame yields one output item
// carrying the decoded action, speed and heading (three packed digits each,
// digits above nine weighted as they stand) and the raw command byte; the
// window is then flushed so no byte serves two frames. Bad frames yield
// nothing and the window keeps sliding. One byte can be taken every clock
// as long as results are taken when offered: a byte sits in the input register,
// the window compare and the constant-multiply decode run on it there, and the
// result lands in the output register as the byte moves on, so out_tvalid rises
// in the cycle after the byte that closes a frame leaves the input register.
// Input stalls only while a result waits in the output register and a byte
// is pending behind it.

module command_frame_receiver_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [cfr_pkg::IN_W-1:0]    in_tdata,   // [7:0] rx_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [cfr_pkg::OUT_W-1:0]   out_tdata   // [2:0] action, [13:3] speed,
                                                  // [24:14] heading,
                                                  // [32:25] command_code, rest zero
);
  import cfr_pkg::*;

  // input register
  logic    s1_valid_r;
  logic    s1_valid_nxt;
  byte_t   s1_byte_r;
  logic    in_acc;
  logic    advance;

  // detector and decoder
  frame_t  frame;
  result_t res;

  // output register
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_res_r;

  // the pending byte moves on once the output register has room
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata[7:0];
    end
  end

  cfr_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (s1_byte_r),
    .frame   (frame)
  );

  cfr_decode u_decode (
    .frame (frame),
    .res   (res)
  );

  // result register: loads on a frame hit, drains when taken
  always_comb begin
    if (advance) begin
      out_valid_nxt = frame.hit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame.hit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_res_r.command_code, out_res_r.heading,
                       out_res_r.speed, out_res_r.action};

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a waiting result");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance) && $past(frame.hit))
    else $error("result appeared without a frame");

  a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.action <= ACT_SPIRAL_OFF)
    else $error("action code out of range");

endmodule
